// ----- rtl/fsnp_pkg.sv -----
// Shared types, codes and character constants of the format string number printer.
package fsnp_pkg;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_U       = 8'h75;
   localparam logic [7:0] CH_D       = 8'h64;
   localparam logic [7:0] CH_X       = 8'h78;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_MINUS   = 8'h2D;

   localparam int DIGITS    = 10;
   localparam int HEX_DIGITS = 8;
   localparam int DIG_IDX_W = $clog2(DIGITS);
   localparam int DIG_CNT_W = $clog2(DIGITS + 1);

   // floor(v / 10) == (v * RECIP10) >> RECIP10_SHIFT for every 32-bit v
   localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
   localparam int          RECIP10_SHIFT = 35;

   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_DEC  = 2'd1;
   localparam logic [1:0] KIND_HEX  = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic        neg;
      logic [31:0] value;
   } cmd_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      if (d < 4'd10) begin
         return CH_ZERO + {4'b0, d};
      end
      return CH_UPPER_A + {4'b0, d} - 8'd10;
   endfunction

endpackage

// ----- rtl/fsnp_if.sv -----
// Valid/ready channel interfaces for format bytes and emitted characters.
interface fsnp_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  fmt_byte;
   logic [31:0] arg_word;

   modport source (output valid, output fmt_byte, output arg_word, input ready);
   modport sink (input valid, input fmt_byte, input arg_word, output ready);
endinterface

interface fsnp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_char;

   modport source (output valid, output out_char, output last_char, input ready);
   modport sink (input valid, input out_char, input last_char, output ready);
endinterface

// ----- rtl/fsnp_front.sv -----
// Front end: accepts format bytes, tracks specifier mode and issues print commands.
module fsnp_front
   import fsnp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   fsnp_req_if.sink req_chan,
   input  logic    cmd_ready,
   output logic    cmd_valid,
   output cmd_type cmd
);

   logic in_spec_ff;
   logic in_spec_in;
   logic accept;
   logic emits;

   assign req_chan.ready = cmd_ready;
   assign accept         = req_chan.valid && cmd_ready;
   assign cmd_valid      = accept && emits;

   always_comb begin
      in_spec_in = in_spec_ff;
      emits      = 1'b0;
      cmd.kind   = KIND_CHAR;
      cmd.neg    = 1'b0;
      cmd.value  = {24'b0, req_chan.fmt_byte};
      if (req_chan.fmt_byte == CH_NUL) begin
         in_spec_in = 1'b0;
      end else if (!in_spec_ff) begin
         if (req_chan.fmt_byte == CH_PERCENT) begin
            in_spec_in = 1'b1;
         end else begin
            emits = 1'b1;
         end
      end else begin
         in_spec_in = 1'b0;
         unique case (req_chan.fmt_byte)
            CH_U: begin
               emits     = 1'b1;
               cmd.kind  = KIND_DEC;
               cmd.value = req_chan.arg_word;
            end
            CH_D: begin
               emits     = 1'b1;
               cmd.kind  = KIND_DEC;
               cmd.neg   = req_chan.arg_word[31];
               cmd.value = req_chan.arg_word[31] ? (32'd0 - req_chan.arg_word)
                                                 : req_chan.arg_word;
            end
            CH_X: begin
               emits     = 1'b1;
               cmd.kind  = KIND_HEX;
               cmd.value = req_chan.arg_word;
            end
            default: emits = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_spec_ff <= 1'b0;
      end else if (accept) begin
         in_spec_ff <= in_spec_in;
      end
   end

endmodule

// ----- rtl/fsnp_queue.sv -----
// Short command queue between the front end and the print engine.
module fsnp_queue
   import fsnp_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    not_full,
   output logic    not_empty,
   input  logic    pop,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type             slots_ff [DEPTH];
   logic    [PTR_W-1:0] wr_ptr_ff;
   logic    [PTR_W-1:0] rd_ptr_ff;
   logic    [CNT_W-1:0] count_ff;
   logic                do_push;
   logic                do_pop;

   assign not_full  = (count_ff != CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign pop_cmd   = slots_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- rtl/fsnp_back.sv -----
// Print engine: converts commands to digits and drives the character output register.
module fsnp_back
   import fsnp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     cmd_valid,
   input  cmd_type  cmd,
   output logic     cmd_pop,
   fsnp_rsp_if.source rsp_chan
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]           state_ff,   state_in;
   logic [31:0]          val_ff,     val_in;
   logic                 neg_ff,     neg_in;
   logic [DIG_CNT_W-1:0] cnt_ff,     cnt_in;
   logic [3:0]           digits_ff [DIGITS];
   logic [3:0]           digits_in [DIGITS];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_char_ff,  rsp_char_in;
   logic                 rsp_last_ff,  rsp_last_in;

   logic                 adv;
   logic [63:0]          prod;
   logic [31:0]          quot;
   logic [31:0]          rem;
   logic [DIG_CNT_W-1:0] cnt_dec;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_char  = rsp_char_ff;
   assign rsp_chan.last_char = rsp_last_ff;

   assign adv     = !rsp_valid_ff || rsp_chan.ready;
   assign prod    = {32'b0, val_ff} * {32'b0, RECIP10};
   assign quot    = {3'b0, prod[63:RECIP10_SHIFT]};
   assign rem     = val_ff - ((quot << 3) + (quot << 1));
   assign cnt_dec = cnt_ff - 1'b1;

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      digits_in    = digits_ff;
      rsp_valid_in = adv ? 1'b0 : rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      cmd_pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.kind == KIND_CHAR) begin
                  if (adv) begin
                     cmd_pop      = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_char_in  = cmd.value[7:0];
                     rsp_last_in  = 1'b1;
                  end
               end else begin
                  cmd_pop = 1'b1;
                  val_in  = cmd.value;
                  neg_in  = cmd.neg;
                  cnt_in  = '0;
                  if (cmd.kind == KIND_HEX) begin
                     for (int i = 0; i < HEX_DIGITS; i++) begin
                        digits_in[i] = cmd.value[4*i +: 4];
                     end
                     cnt_in   = DIG_CNT_W'(HEX_DIGITS);
                     state_in = ST_EMIT;
                  end else begin
                     state_in = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            digits_in[cnt_ff[DIG_IDX_W-1:0]] = rem[3:0];
            cnt_in = cnt_ff + 1'b1;
            val_in = quot;
            if (quot == 32'd0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (adv) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  rsp_char_in = CH_MINUS;
                  rsp_last_in = 1'b0;
                  neg_in      = 1'b0;
               end else begin
                  rsp_char_in = digit_char(digits_ff[cnt_dec[DIG_IDX_W-1:0]]);
                  rsp_last_in = (cnt_dec == '0);
                  cnt_in      = cnt_dec;
                  if (cnt_dec == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      digits_ff   <= digits_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ----- rtl/format_string_number_printer.sv -----
// Format string number printer: takes one format byte with a 32-bit argument per item and
// emits the characters it produces (plain echo, %u and %d in decimal, %x as eight uppercase
// hex digits), one character per output item, with last_char marking the final one.
// A plain character goes into the output register once that register is free; %x loads its
// eight digits at once and then emits them; %u and %d first produce their digits with the
// one-digit-per-cycle divide-by-ten step, then emit a minus sign if negative and the digits
// through the single output register. Bytes that emit nothing issue no command. The
// command queue lets format bytes keep arriving while a number is still being printed.
module format_string_number_printer
   import fsnp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic       clock,
   input  logic       reset,
   fsnp_req_if.sink   req_chan,
   fsnp_rsp_if.source rsp_chan
);

   cmd_type front_cmd;
   cmd_type back_cmd;
   logic    front_valid;
   logic    queue_not_full;
   logic    queue_not_empty;
   logic    back_pop;

   fsnp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_ready (queue_not_full),
      .cmd_valid (front_valid),
      .cmd       (front_cmd)
   );

   fsnp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_cmd  (front_cmd),
      .not_full  (queue_not_full),
      .not_empty (queue_not_empty),
      .pop       (back_pop),
      .pop_cmd   (back_cmd)
   );

   fsnp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_not_empty),
      .cmd       (back_cmd),
      .cmd_pop   (back_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- sim/fsnp_checker.sv -----
// Scoreboard that predicts the printed characters and compares them against the result channel.
module fsnp_checker
   import fsnp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   fsnp_req_if  req_mon,
   fsnp_rsp_if  rsp_mon,
   output int   pending,
   output int   failures
);

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_char;
   } printed_char_type;

   printed_char_type expected_chars[$];
   logic             spec_mode;

   initial begin
      pending  = 0;
      failures = 0;
   end

   task automatic queue_char(input logic [7:0] ch, input logic last);
      printed_char_type pc;
      pc.out_char  = ch;
      pc.last_char = last;
      expected_chars.push_back(pc);
   endtask

   task automatic queue_decimal(input logic [31:0] mag);
      logic [3:0]  digs[DIGITS];
      logic [31:0] rest;
      int          n;
      rest = mag;
      n    = 0;
      do begin
         digs[n] = 4'(rest % 32'd10);
         rest    = rest / 32'd10;
         n++;
      end while (rest != 32'd0);
      for (int i = n - 1; i >= 0; i--) begin
         queue_char(CH_ZERO + {4'b0, digs[i]}, i == 0);
      end
   endtask

   task automatic queue_hex(input logic [31:0] value);
      logic [3:0] nib;
      for (int i = HEX_DIGITS - 1; i >= 0; i--) begin
         nib = value[i*4 +: 4];
         if (nib < 4'd10) begin
            queue_char(CH_ZERO + {4'b0, nib}, i == 0);
         end else begin
            queue_char(CH_UPPER_A + {4'b0, nib} - 8'd10, i == 0);
         end
      end
   endtask

   task automatic predict_printout(input logic [7:0] fmt, input logic [31:0] arg);
      if (fmt == CH_NUL) begin
         spec_mode = 1'b0;
      end else if (!spec_mode) begin
         if (fmt == CH_PERCENT) begin
            spec_mode = 1'b1;
         end else begin
            queue_char(fmt, 1'b1);
         end
      end else begin
         spec_mode = 1'b0;
         if (fmt == CH_U) begin
            queue_decimal(arg);
         end else if (fmt == CH_D) begin
            if (arg[31]) begin
               queue_char(CH_MINUS, 1'b0);
               queue_decimal(32'd0 - arg);
            end else begin
               queue_decimal(arg);
            end
         end else if (fmt == CH_X) begin
            queue_hex(arg);
         end
      end
   endtask

   always @(posedge clock) begin
      printed_char_type exp_pc;
      if (reset) begin
         spec_mode = 1'b0;
         expected_chars.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            predict_printout(req_mon.fmt_byte, req_mon.arg_word);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_chars.size() == 0) begin
               $error("out_char: no character expected, got %h", rsp_mon.out_char);
               failures <= failures + 1;
            end else begin
               exp_pc = expected_chars.pop_front();
               if (rsp_mon.out_char !== exp_pc.out_char) begin
                  $error("out_char: expected %h, got %h", exp_pc.out_char, rsp_mon.out_char);
                  failures <= failures + 1;
               end else if (rsp_mon.last_char !== exp_pc.last_char) begin
                  $error("last_char: expected %b, got %b", exp_pc.last_char,
                         rsp_mon.last_char);
                  failures <= failures + 1;
               end
            end
         end
      end
      pending <= expected_chars.size();
   end

endmodule

// ----- sim/testbench.sv -----
// Top of the printer testbench: clock, reset, format byte stimulus and the final verdict.
module testbench
   import fsnp_pkg::*;
();

   localparam logic [7:0] CH_S = 8'h73;
   localparam logic [7:0] CH_Q = 8'h71;
   localparam int TOTAL_ITEMS  = 410;
   localparam int PHASE_ITEMS  = 128;

   logic clock;
   logic reset;
   int   tx_idle_pct;
   int   rx_idle_pct;
   int   items_sent;
   int   chars_pending;
   int   fail_count;

   fsnp_req_if req ();
   fsnp_rsp_if rsp ();

   format_string_number_printer uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   fsnp_checker u_checker (
      .clock    (clock),
      .reset    (reset),
      .req_mon  (req),
      .rsp_mon  (rsp),
      .pending  (chars_pending),
      .failures (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #10 clock = ~clock;
      end
   end

   initial begin
      #10000000;
      $display("format_string_number_printer verification failed");
      $finish;
   end

   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send_fmt(input logic [7:0] fmt, input logic [31:0] arg);
      while ($urandom_range(99) < tx_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid    <= 1'b1;
      req.fmt_byte <= fmt;
      req.arg_word <= arg;
      @(posedge clock);
      while (!req.ready) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic drain;
      req.valid <= 1'b0;
      @(posedge clock);
      while (chars_pending != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [31:0] shaped_arg();
      logic [31:0] mag;
      mag = $urandom >> $urandom_range(31, 0);
      case ($urandom_range(3))
         0: return $urandom;
         1: return mag;
         2: return 32'd0 - mag;
         default: begin
            case ($urandom_range(3))
               0: return 32'h0000_0000;
               1: return 32'h8000_0000;
               2: return 32'h7FFF_FFFF;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   task automatic random_items(input int stop_at);
      int         pick;
      logic [7:0] spec;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            send_fmt(8'($urandom_range(255)), $urandom);
         end else if (pick < 85) begin
            send_fmt(CH_PERCENT, $urandom);
            case ($urandom_range(2))
               0: spec = CH_U;
               1: spec = CH_D;
               default: spec = CH_X;
            endcase
            send_fmt(spec, shaped_arg());
         end else begin
            send_fmt(CH_PERCENT, $urandom);
            send_fmt(8'($urandom_range(255)), $urandom);
         end
      end
   endtask

   initial begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      items_sent  = 0;
      reset        <= 1'b1;
      req.valid    <= 1'b0;
      req.fmt_byte <= CH_NUL;
      req.arg_word <= 32'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct = 37;
      rx_idle_pct = 83;
      send_fmt(CH_UPPER_A, 32'd0);
      send_fmt(8'hFF, 32'hFFFF_FFFF);
      send_fmt(8'h01, 32'd0);
      send_fmt(CH_PERCENT, 32'd0);
      send_fmt(CH_U, 32'd0);
      send_fmt(CH_PERCENT, 32'd0);
      send_fmt(CH_U, 32'hFFFF_FFFF);
      send_fmt(CH_PERCENT, 32'd0);
      send_fmt(CH_D, 32'h8000_0000);
      send_fmt(CH_PERCENT, 32'd0);
      send_fmt(CH_D, 32'hFFFF_FFFF);
      send_fmt(CH_PERCENT, 32'd0);
      send_fmt(CH_D, 32'h7FFF_FFFF);
      send_fmt(CH_PERCENT, 32'd0);
      send_fmt(CH_X, 32'd0);
      send_fmt(CH_PERCENT, 32'd0);
      send_fmt(CH_X, 32'hFFFF_FFFF);
      send_fmt(CH_PERCENT, 32'd0);
      send_fmt(CH_S, 32'h1234_5678);
      send_fmt(CH_PERCENT, 32'd0);
      send_fmt(CH_PERCENT, 32'd7);
      send_fmt(CH_PERCENT, 32'd0);
      send_fmt(CH_NUL, 32'd5);
      send_fmt(CH_NUL, 32'd0);
      send_fmt(CH_PERCENT, 32'd0);
      send_fmt(CH_Q, 32'd9);
      drain();

      random_items(items_sent + PHASE_ITEMS);
      drain();

      tx_idle_pct = 83;
      rx_idle_pct = 37;
      random_items(items_sent + PHASE_ITEMS);
      drain();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_items(TOTAL_ITEMS);
      drain();
      repeat (30) @(posedge clock);

      if (fail_count == 0) begin
         $display("format_string_number_printer verification clean");
      end else begin
         $display("format_string_number_printer verification failed");
      end
      $finish;
   end

endmodule
